// ===== hdl/mi3_pkg.sv =====
package mi3_pkg;

  localparam int Dim = 3;
  localparam int NElem = Dim * Dim;
  localparam int ElemW = 32;
  localparam int CofW = 65;          // exact cofactor width
  localparam int DetW = 97;          // exact determinant width
  localparam int NumW = CofW + 32;   // cofactor scaled by 2^32
  localparam int QW = NumW;          // quotient magnitude width
  localparam int DataW = NElem * ElemW;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0] cof_t;
  typedef logic signed [DetW-1:0] det_t;
  typedef logic [NumW-1:0] num_t;
  typedef logic [DetW-1:0] mag_t;

  // Side data that travels alongside the division pipeline
  typedef struct packed {
    logic [DataW-1:0] raw;
    logic             sing;
  } side_t;

  // Magnitude of a 97-bit signed value
  function automatic mag_t det_abs(det_t d);
    mag_t m;
    m = d[DetW-1] ? mag_t'(-d) : mag_t'(d);
    return m;
  endfunction

endpackage

// ===== hdl/mi3_div_lane.sv =====
// One division lane: unsigned num*2^32 / den, restoring, one quotient bit
// per pipeline stage, then sign and saturation.
module mi3_div_lane (
  input  logic                  clk,
  input  logic                  en,
  input  mi3_pkg::cof_t         cof,
  input  mi3_pkg::mag_t         den,
  input  logic                  den_neg,
  output mi3_pkg::elem_t        res
);

  localparam int N = mi3_pkg::NumW;
  localparam int RW = mi3_pkg::DetW + 1;

  logic [N-1:0]  num_s [N+1];
  logic [RW-1:0] rem_s [N+1];
  logic [N-1:0]  q_s   [N+1];
  mi3_pkg::mag_t den_s [N+1];
  logic          neg_s [N+1];

  logic [mi3_pkg::CofW-1:0] cmag;
  assign cmag = cof[mi3_pkg::CofW-1] ? -cof : cof;

  always_ff @(posedge clk) begin
    if (en) begin
      num_s[0] <= {cmag, 32'd0};
      rem_s[0] <= '0;
      q_s[0]   <= '0;
      den_s[0] <= den;
      neg_s[0] <= cof[mi3_pkg::CofW-1] ^ den_neg;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [RW-1:0] sh;
    logic [RW-1:0] df;
    assign sh = {rem_s[i][RW-2:0], num_s[i][N-1-i]};
    assign df = sh - {1'b0, den_s[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        num_s[i+1] <= num_s[i];
        den_s[i+1] <= den_s[i];
        neg_s[i+1] <= neg_s[i];
        rem_s[i+1] <= df[RW-1] ? sh : df;
        q_s[i+1]   <= {q_s[i][N-2:0], ~df[RW-1]};
      end
    end
  end

  logic [N-1:0] q;
  assign q = q_s[N];
  always_comb begin
    if (neg_s[N]) begin
      if (q > N'(33'h080000000)) res = 32'sh80000000;
      else res = mi3_pkg::elem_t'(-q[31:0]);
    end else begin
      if (q > N'(32'h7FFFFFFF)) res = 32'sh7FFFFFFF;
      else res = mi3_pkg::elem_t'(q[31:0]);
    end
  end

endmodule

// ===== hdl/mi3_cofactor.sv =====
// Cofactors (2 stages: products, difference) then determinant (3 stages:
// split products, recombine, sum). Cofactors are delayed to line up with
// the determinant.
module mi3_cofactor (
  input  logic                           clk,
  input  logic                           en,
  input  logic [mi3_pkg::DataW-1:0]      mat,
  output mi3_pkg::cof_t                  cof [mi3_pkg::NElem],
  output mi3_pkg::det_t                  det
);

  localparam int P = 2 * mi3_pkg::ElemW;

  mi3_pkg::elem_t a [3][3];
  for (genvar c = 0; c < 3; c++) begin : g_c
    for (genvar r = 0; r < 3; r++) begin : g_r
      assign a[r][c] = mat[(c*3+r)*mi3_pkg::ElemW +: mi3_pkg::ElemW];
    end
  end

  logic signed [P-1:0] pp [9];
  logic signed [P-1:0] ps [9];
  mi3_pkg::elem_t a0 [3], a0d [3];
  mi3_pkg::cof_t  cf [9], cfd [9], cfd2 [9], cfd3 [9];
  logic signed [P+1:0] plo [3];   // a0 * cofactor bits 32:0
  logic signed [P-1:0] phi [3];   // a0 * cofactor bits 64:33
  logic signed [mi3_pkg::DetW-1:0] tp [3];

  for (genvar r = 0; r < 3; r++) begin : g_cr
    for (genvar c = 0; c < 3; c++) begin : g_cc
      localparam int R1 = (r + 1) % 3, R2 = (r + 2) % 3;
      localparam int C1 = (c + 1) % 3, C2 = (c + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          pp[r*3+c] <= a[R1][C1] * a[R2][C2];
          ps[r*3+c] <= a[R1][C2] * a[R2][C1];
          cf[r*3+c] <= mi3_pkg::CofW'(pp[r*3+c]) - mi3_pkg::CofW'(ps[r*3+c]);
          cfd[r*3+c] <= cf[r*3+c];
          cfd2[r*3+c] <= cfd[r*3+c];
          cfd3[r*3+c] <= cfd2[r*3+c];
        end
      end
      assign cof[r*3+c] = cfd3[r*3+c];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_d
    always_ff @(posedge clk) begin
      if (en) begin
        a0[c]  <= a[0][c];
        a0d[c] <= a0[c];
        plo[c] <= a0d[c] * $signed({1'b0, cf[c][32:0]});
        phi[c] <= a0d[c] * $signed(cf[c][mi3_pkg::CofW-1:33]);
        tp[c]  <= (mi3_pkg::DetW'(phi[c]) <<< 33) + mi3_pkg::DetW'(plo[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) det <= tp[0] + tp[1] + tp[2];
  end

endmodule

// ===== hdl/matrix_inverse_3x3.sv =====
// Pipeline: cofactor/determinant stages, 98 division stages, 1 output
//   register between the accepted beat and the output beat.
// One matrix per cycle unless stalled; nine division lanes run in parallel.
// The whole pipe stalls when the output register is full and not taken.
// Reset (rst, synchronous) clears the valid bits only; data is not reset.
module matrix_inverse_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // r0c0,r1c0,r2c0,r0c1,r1c1,r2c1,r0c2,r1c2,r2c2 from bit 0, 32 bits each
  input  logic [mi3_pkg::DataW-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // out r0c0..r2c2 in the same order, 32 bits each
  output logic [mi3_pkg::DataW-1:0]     m_tdata,
  output logic                          m_tuser  // singular
);

  localparam int LatC = 5;
  localparam int LatD = mi3_pkg::NumW + 1;
  localparam int Lat = LatC + LatD;

  logic en;
  logic [Lat-1:0] vld;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // valid shift line, advances with the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_tvalid};
      m_tvalid <= vld[Lat-1];
    end
  end

  mi3_pkg::cof_t cof [mi3_pkg::NElem];
  mi3_pkg::det_t det;

  mi3_cofactor u_cof (
    .clk (clk),
    .en  (en),
    .mat (s_tdata),
    .cof (cof),
    .det (det)
  );

  // raw matrix rides with the pipe for the singular pass-through
  logic [mi3_pkg::DataW-1:0] raw_d [LatC];
  always_ff @(posedge clk) begin
    if (en) begin
      raw_d[0] <= s_tdata;
      for (int i = 1; i < LatC; i++) raw_d[i] <= raw_d[i-1];
    end
  end

  mi3_pkg::side_t side [LatD];
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{raw: raw_d[LatC-1], sing: (det == '0)};
      for (int i = 1; i < LatD; i++) side[i] <= side[i-1];
    end
  end

  mi3_pkg::mag_t dmag;
  assign dmag = mi3_pkg::det_abs(det);

  mi3_pkg::elem_t q [mi3_pkg::NElem];
  // output (r,c) = C(c,r)/D, laid out at c*3+r; cofactor index c*3+r is C(c,r)
  for (genvar k = 0; k < mi3_pkg::NElem; k++) begin : g_lane
    mi3_div_lane u_div (
      .clk     (clk),
      .en      (en),
      .cof     (cof[k]),
      .den     (dmag),
      .den_neg (det[mi3_pkg::DetW-1]),
      .res     (q[k])
    );
  end

  // merge: pick quotients or pass-through
  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= side[LatD-1].sing;
      for (int k = 0; k < mi3_pkg::NElem; k++) begin
        m_tdata[k*mi3_pkg::ElemW +: mi3_pkg::ElemW] <= side[LatD-1].sing ?
          side[LatD-1].raw[k*mi3_pkg::ElemW +: mi3_pkg::ElemW] : q[k];
      end
    end
  end

endmodule
